// File: sv/pfe_pkg.sv
// shared types and constants for the playfair digraph encryptor
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int CELLS       = 25;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LAST_LETTER = 5'd25;

    // raw operation codes on the input field
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_KEY    = 3'd1;
    localparam logic [2:0] OP_FINISH = 3'd2;
    localparam logic [2:0] OP_PLAIN  = 3'd3;
    localparam logic [2:0] OP_END    = 3'd4;

    // classified commands passed from front to back
    typedef enum logic [2:0] {
        CMD_START,
        CMD_KEY,
        CMD_FINISH,
        CMD_PLAIN,
        CMD_END
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [4:0] letter;
    } cmd_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_in;
    } item_t;

    typedef struct packed {
        logic [6:0] cipher_first;
        logic [6:0] cipher_second;
    } result_t;

endpackage

// File: sv/playfair_digraph_encryptor.sv
// top level of the playfair digraph encryptor: front, command queue, back
//
//  channel | direction | payload           | handshake
//  --------+-----------+-------------------+-----------------------
//  item    | in        | operation, char_in| item_valid / item_stall
//  result  | out       | two cipher letters| result_valid / result_stall
//
// rates: the front takes one transaction a cycle while the queue has room; the back pops
// start, key or a lone plaintext letter and acts on it at once, walks finish key as a pop
// then one alphabet letter a cycle, and runs a pair as two table reads and an output load
// path: front hold register, queue slot, cell registers, letter registers, output register
// reset: asynchronous, active low, control state only; the first finish key fills the square
// stalls: result_stall holds the output register and then the back; the queue fills
// and item_stall rises, so each side stalls on its own
`timescale 1ns / 1ps

module playfair_digraph_encryptor #(
    parameter int QueueDepth = pfe_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pfe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pfe_pkg::result_t result
);

    // classified commands from front into the queue
    logic          front_push;
    pfe_pkg::cmd_t front_cmd;
    logic          queue_full;

    // queue head into the back
    logic          head_valid;
    pfe_pkg::cmd_t head_cmd;
    logic          head_pop;

    // front: letter folding and operation decode, drops no-op transactions
    pfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_push   (front_push),
        .cmd        (front_cmd),
        .cmd_full   (queue_full)
    );

    pfe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    // back: key square, pairing state and encryption, owns the output register
    pfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (head_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: sv/pfe_front.sv
// front end: takes input transactions, folds letters and classifies operations
`timescale 1ns / 1ps

module pfe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  pfe_pkg::item_t item,
    output logic           cmd_push,
    output pfe_pkg::cmd_t  cmd,
    input  logic           cmd_full
);

    logic          hold_valid_reg;
    logic          hold_valid_next;
    pfe_pkg::cmd_t hold_cmd_reg;
    pfe_pkg::cmd_t hold_cmd_next;
    logic          letter_ok;
    logic [4:0]    letter;
    logic [4:0]    diff;
    logic          keep;
    pfe_pkg::cmd_t cls_cmd;
    logic          accept;

    // letter folding, j merged into i
    always_comb
    begin
        letter_ok = 1'b1;
        diff      = 5'd0;
        if (item.char_in >= 8'd65 && item.char_in <= 8'd90)
        begin
            diff = 5'(item.char_in - 8'd65);
        end
        else if (item.char_in >= 8'd97 && item.char_in <= 8'd122)
        begin
            diff = 5'(item.char_in - 8'd97);
        end
        else
        begin
            letter_ok = 1'b0;
        end
        letter = (diff == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : diff;
    end

    // drop what changes nothing: non-letters on key and plaintext, unknown codes
    always_comb
    begin
        keep           = 1'b0;
        cls_cmd.letter = letter;
        cls_cmd.op     = pfe_pkg::CMD_START;
        case (item.operation)
            pfe_pkg::OP_START:
            begin
                keep       = 1'b1;
                cls_cmd.op = pfe_pkg::CMD_START;
            end
            pfe_pkg::OP_KEY:
            begin
                keep       = letter_ok;
                cls_cmd.op = pfe_pkg::CMD_KEY;
            end
            pfe_pkg::OP_FINISH:
            begin
                keep       = 1'b1;
                cls_cmd.op = pfe_pkg::CMD_FINISH;
            end
            pfe_pkg::OP_PLAIN:
            begin
                keep       = letter_ok;
                cls_cmd.op = pfe_pkg::CMD_PLAIN;
            end
            pfe_pkg::OP_END:
            begin
                keep       = 1'b1;
                cls_cmd.op = pfe_pkg::CMD_END;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_push   = hold_valid_reg && !cmd_full;
    assign cmd        = hold_cmd_reg;
    assign item_stall = hold_valid_reg && cmd_full;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (accept)
        begin
            hold_valid_next = keep;
            hold_cmd_next   = cls_cmd;
        end
        else if (cmd_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

// File: sv/pfe_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module pfe_queue #(
    parameter int Depth = pfe_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pfe_pkg::cmd_t head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    pfe_pkg::cmd_t   slots [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/pfe_back.sv
// back end: key square, plaintext pairing, filler choice and pair encryption
`timescale 1ns / 1ps

module pfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  pfe_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output pfe_pkg::result_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_MAP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } rc_t;

    function automatic logic [4:0] next_letter(input logic [4:0] l);
        next_letter = (l == pfe_pkg::LAST_LETTER) ? 5'd0 : l + 5'd1;
    endfunction

    // cell number to row and column, compare chain instead of a divide
    function automatic rc_t split_cell(input logic [4:0] c);
        rc_t        rc;
        logic [4:0] base;
        if (c >= 5'd20)
        begin
            rc.row = 3'd4;
            base   = 5'd20;
        end
        else if (c >= 5'd15)
        begin
            rc.row = 3'd3;
            base   = 5'd15;
        end
        else if (c >= 5'd10)
        begin
            rc.row = 3'd2;
            base   = 5'd10;
        end
        else if (c >= 5'd5)
        begin
            rc.row = 3'd1;
            base   = 5'd5;
        end
        else
        begin
            rc.row = 3'd0;
            base   = 5'd0;
        end
        rc.col     = 3'(c - base);
        split_cell = rc;
    endfunction

    function automatic logic [4:0] join_cell(input logic [2:0] row, input logic [2:0] col);
        join_cell = {row[2:0], 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [2:0] step5(input logic [2:0] v);
        step5 = (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    // square tables
    logic [4:0] letter_cell [26];
    logic [4:0] cell_letter [pfe_pkg::CELLS];

    state_t           state_reg;
    state_t           state_next;
    logic [25:0]      placed_reg;
    logic [25:0]      placed_next;
    logic [4:0]       next_cell_reg;
    logic [4:0]       next_cell_next;
    logic             pending_valid_reg;
    logic             pending_valid_next;
    logic [4:0]       pending_letter_reg;
    logic [4:0]       pending_letter_next;
    logic [4:0]       filler_reg;
    logic [4:0]       filler_next;
    logic [4:0]       fill_idx_reg;
    logic [4:0]       fill_idx_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    pfe_pkg::result_t result_reg;
    pfe_pkg::result_t result_next;

    logic [4:0] pa_reg;
    logic [4:0] pb_reg;
    logic [4:0] fa_reg;
    logic [4:0] fb_reg;

    logic       place_req;
    logic [4:0] place_l;
    logic       place_en;
    logic       rd_en;
    logic [4:0] rd_a;
    logic [4:0] rd_b;
    logic [4:0] filler_pick;
    rc_t        rc_a;
    rc_t        rc_b;
    logic [4:0] na;
    logic [4:0] nb;

    // filler: at most the pending letter and j are skipped
    always_comb
    begin
        filler_pick = filler_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (filler_pick == pending_letter_reg || filler_pick == pfe_pkg::LETTER_J)
            begin
                filler_pick = next_letter(filler_pick);
            end
        end
    end

    // playfair rules on the two looked-up cells
    always_comb
    begin
        rc_a = split_cell(pa_reg);
        rc_b = split_cell(pb_reg);
        if (rc_a.row == rc_b.row)
        begin
            na = join_cell(rc_a.row, step5(rc_a.col));
            nb = join_cell(rc_b.row, step5(rc_b.col));
        end
        else if (rc_a.col == rc_b.col)
        begin
            na = join_cell(step5(rc_a.row), rc_a.col);
            nb = join_cell(step5(rc_b.row), rc_b.col);
        end
        else
        begin
            na = join_cell(rc_a.row, rc_b.col);
            nb = join_cell(rc_b.row, rc_a.col);
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        placed_next         = placed_reg;
        next_cell_next      = next_cell_reg;
        pending_valid_next  = pending_valid_reg;
        pending_letter_next = pending_letter_reg;
        filler_next         = filler_reg;
        fill_idx_next       = fill_idx_reg;
        result_valid_next   = result_valid_reg && result_stall;
        result_next         = result_reg;
        cmd_pop             = 1'b0;
        place_req           = 1'b0;
        place_l             = cmd.letter;
        rd_en               = 1'b0;
        rd_a                = pending_letter_reg;
        rd_b                = cmd.letter;
        place_en            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        pfe_pkg::CMD_START:
                        begin
                            placed_next        = '0;
                            next_cell_next     = '0;
                            pending_valid_next = 1'b0;
                            filler_next        = '0;
                        end
                        pfe_pkg::CMD_KEY:
                        begin
                            place_req = 1'b1;
                        end
                        pfe_pkg::CMD_FINISH:
                        begin
                            fill_idx_next = '0;
                            state_next    = S_FILL;
                        end
                        pfe_pkg::CMD_PLAIN:
                        begin
                            if (!pending_valid_reg)
                            begin
                                pending_valid_next  = 1'b1;
                                pending_letter_next = cmd.letter;
                            end
                            else if (cmd.letter != pending_letter_reg)
                            begin
                                rd_en              = 1'b1;
                                pending_valid_next = 1'b0;
                                state_next         = S_MAP;
                            end
                            else
                            begin
                                // doubled letter: pair with filler, new letter waits
                                rd_en               = 1'b1;
                                rd_b                = filler_pick;
                                filler_next         = next_letter(filler_pick);
                                pending_letter_next = cmd.letter;
                                state_next          = S_MAP;
                            end
                        end
                        pfe_pkg::CMD_END:
                        begin
                            if (pending_valid_reg)
                            begin
                                rd_en              = 1'b1;
                                rd_b               = filler_pick;
                                filler_next        = next_letter(filler_pick);
                                pending_valid_next = 1'b0;
                                state_next         = S_MAP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                place_l       = fill_idx_reg;
                place_req     = (fill_idx_reg != pfe_pkg::LETTER_J);
                fill_idx_next = next_letter(fill_idx_reg);
                if (fill_idx_reg == pfe_pkg::LAST_LETTER)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next         = 1'b1;
                    result_next.cipher_first  = 7'd65 + {2'b00, fa_reg};
                    result_next.cipher_second = 7'd65 + {2'b00, fb_reg};
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (place_req && next_cell_reg < 5'(pfe_pkg::CELLS) && !placed_reg[place_l])
        begin
            place_en             = 1'b1;
            placed_next[place_l] = 1'b1;
            next_cell_next       = next_cell_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            placed_reg         <= '0;
            next_cell_reg      <= '0;
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= '0;
            filler_reg         <= '0;
            fill_idx_reg       <= '0;
            result_valid_reg   <= 1'b0;
            result_reg         <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            placed_reg         <= placed_next;
            next_cell_reg      <= next_cell_next;
            pending_valid_reg  <= pending_valid_next;
            pending_letter_reg <= pending_letter_next;
            filler_reg         <= filler_next;
            fill_idx_reg       <= fill_idx_next;
            result_valid_reg   <= result_valid_next;
            result_reg         <= result_next;
        end
    end

    // table writes and registered table reads
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            letter_cell[place_l]       <= next_cell_reg;
            cell_letter[next_cell_reg] <= place_l;
        end
        if (rd_en)
        begin
            pa_reg <= letter_cell[rd_a];
            pb_reg <= letter_cell[rd_b];
        end
        if (state_reg == S_MAP)
        begin
            fa_reg <= cell_letter[na];
            fb_reg <= cell_letter[nb];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/pfe_checker.sv
// port checker for the playfair digraph encryptor, bound to the top level
`timescale 1ns / 1ps

module pfe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input pfe_pkg::result_t result
);

    // a stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its letters
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // both cipher letters are uppercase ascii
    a_result_letters: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.cipher_first >= 7'd65 && result.cipher_first <= 7'd90
                          && result.cipher_second >= 7'd65 && result.cipher_second <= 7'd90))
        else $error("cipher letter out of range");

    // handshake outputs are always known
    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({item_stall, result_valid}))
        else $error("unknown handshake output");

endmodule

bind playfair_digraph_encryptor pfe_checker u_checker (.*);

// File: bench/tb_playfair_digraph_encryptor.sv
// self-checking testbench for the playfair digraph encryptor
`timescale 1ns / 1ps

module tb_playfair_digraph_encryptor;

    localparam int LETTERS       = 26;
    localparam int SIDE          = 5;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_AT_ITEM  = 150;   // long receiver hold-off starts here
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 150;   // lets queued finish-key walks drain before the summary
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // operation codes the block must ignore
    localparam logic [2:0] OP_SPARE_FIRST = pfe_pkg::OP_END + 3'd1;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    // ------------------------------------------------------------------
    // predictor and scoreboard: builds the square, pairs the plaintext
    // and queues the cipher pairs the block owes us
    // ------------------------------------------------------------------
    class pair_scoreboard;
        logic [4:0]       letter_cell [LETTERS];
        logic [4:0]       cell_letter [pfe_pkg::CELLS];
        bit [LETTERS-1:0] placed;
        int               next_cell;
        int               filler_next;
        bit               pending_valid;
        int               pending_letter;
        pfe_pkg::result_t expected_pairs [$];
        int               mismatches;
        int               pairs_checked;

        function new();
            foreach (letter_cell[i]) letter_cell[i] = '0;
            foreach (cell_letter[i]) cell_letter[i] = '0;
            placed         = '0;
            next_cell      = 0;
            filler_next    = 0;
            pending_valid  = 1'b0;
            pending_letter = 0;
            mismatches     = 0;
            pairs_checked  = 0;
        endfunction

        // letter index 0..25, J merged into I, anything else gives LETTERS
        function int fold_char(logic [7:0] c);
            int l;
            if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
                l = int'(c - ASCII_UPPER_A);
            else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
                l = int'(c - ASCII_LOWER_A);
            else
                return LETTERS;
            return (l == pfe_pkg::LETTER_J) ? int'(pfe_pkg::LETTER_I) : l;
        endfunction

        function void place(int l);
            if (l >= LETTERS || next_cell >= pfe_pkg::CELLS)
                return;
            if (placed[l])
                return;
            letter_cell[l]         = 5'(next_cell);
            cell_letter[next_cell] = 5'(l);
            placed[l]              = 1'b1;
            next_cell++;
        endfunction

        // append a pair the block owes
        function void owe_pair(pfe_pkg::result_t r);
            expected_pairs.insert(expected_pairs.size(), r);
        endfunction

        // rotating filler, skips the letter being paired and J, also past the wrap
        function int take_filler(int avoid);
            int f;
            f = filler_next;
            while (f == avoid || f == pfe_pkg::LETTER_J)
                f = (f + 1) % LETTERS;
            filler_next = (f + 1) % LETTERS;
            return f;
        endfunction

        function pfe_pkg::result_t encode_pair(int a, int b);
            int               pa, pb, ra, ca, rb, cb, na, nb;
            pfe_pkg::result_t r;
            pa = letter_cell[a];
            pb = letter_cell[b];
            ra = pa / SIDE;
            ca = pa % SIDE;
            rb = pb / SIDE;
            cb = pb % SIDE;
            if (ra == rb)
            begin
                na = ra * SIDE + (ca + 1) % SIDE;
                nb = rb * SIDE + (cb + 1) % SIDE;
            end
            else if (ca == cb)
            begin
                na = ((ra + 1) % SIDE) * SIDE + ca;
                nb = ((rb + 1) % SIDE) * SIDE + cb;
            end
            else
            begin
                na = ra * SIDE + cb;
                nb = rb * SIDE + ca;
            end
            r.cipher_first  = 7'(ASCII_UPPER_A + cell_letter[na]);
            r.cipher_second = 7'(ASCII_UPPER_A + cell_letter[nb]);
            return r;
        endfunction

        // one accepted input transaction
        function void note_item(pfe_pkg::item_t it);
            int l;
            int f;
            l = fold_char(it.char_in);
            case (it.operation)
                pfe_pkg::OP_START:
                begin
                    placed        = '0;
                    next_cell     = 0;
                    pending_valid = 1'b0;
                    filler_next   = 0;
                end
                pfe_pkg::OP_KEY: place(l);
                pfe_pkg::OP_FINISH:
                begin
                    for (int i = 0; i < LETTERS; i++)
                        if (i != pfe_pkg::LETTER_J)
                            place(i);
                    if (placed[pfe_pkg::LETTER_I])
                        letter_cell[pfe_pkg::LETTER_J] = letter_cell[pfe_pkg::LETTER_I];
                end
                pfe_pkg::OP_PLAIN:
                begin
                    if (l < LETTERS)
                    begin
                        if (!pending_valid)
                        begin
                            pending_letter = l;
                            pending_valid  = 1'b1;
                        end
                        else if (l != pending_letter)
                        begin
                            owe_pair(encode_pair(pending_letter, l));
                            pending_valid = 1'b0;
                        end
                        else
                        begin
                            f = take_filler(pending_letter);
                            owe_pair(encode_pair(pending_letter, f));
                            pending_letter = l;
                        end
                    end
                end
                pfe_pkg::OP_END:
                begin
                    if (pending_valid)
                    begin
                        f = take_filler(pending_letter);
                        owe_pair(encode_pair(pending_letter, f));
                        pending_valid = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        // one accepted result transaction
        function void check_result(pfe_pkg::result_t got);
            pfe_pkg::result_t want;
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pair: cipher_first=%c cipher_second=%c",
                             got.cipher_first, got.cipher_second);
                return;
            end
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (got.cipher_first !== want.cipher_first
                    || got.cipher_second !== want.cipher_second)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("pair %0d: cipher_first exp %c got %c, cipher_second exp %c got %c",
                             pairs_checked, want.cipher_first, got.cipher_first,
                             want.cipher_second, got.cipher_second);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, block
    // ------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    pfe_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    pfe_pkg::result_t result;

    always #10 clk = ~clk;

    playfair_digraph_encryptor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    pair_scoreboard sb = new();

    int cycles          = 0;
    int items_accepted  = 0;
    int messages_sent   = 0;
    int burst_left      = 0;
    bit held_off        = 1'b0;

    always @(posedge clk)
        cycles <= cycles + 1;

    // watchdog
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d pairs still owed",
                 cycles, sb.expected_pairs.size());
        $display("Some tests failed");
        $finish;
    end

    // result monitor: a transaction moves when valid is high and stall is low
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // ------------------------------------------------------------------
    // receiver: stall density steps through four percentages in turn, and once
    // it holds off for a long stretch so the queue fills and the input stalls
    // ------------------------------------------------------------------
    initial
    begin
        int stall_percent [4];
        int rx_cycle;
        stall_percent = '{0, 25, 75, 50};
        rx_cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && items_accepted >= HOLD_AT_ITEM)
            begin
                held_off = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rx_cycle++;
            result_stall <= ($urandom_range(0, 99) < stall_percent[(rx_cycle / 400) % 4]);
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one transaction, wait for it to be taken, then maybe idle;
    // always entered right after a rising edge
    task automatic offer(input logic [2:0] op, input logic [7:0] ch);
        pfe_pkg::item_t it;
        int             gap;
        it.operation = op;
        it.char_in   = ch;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        items_accepted++;
        // bursts of random length, random gaps between them
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // letter 0..25 as an upper- or lowercase byte
    function automatic logic [7:0] letter_byte(int l);
        if ($urandom_range(0, 1))
            return 8'(ASCII_UPPER_A + l);
        return 8'(ASCII_LOWER_A + l);
    endfunction

    // one message with random content; mostly well formed
    task automatic random_message();
        int kind;
        int key_len;
        int text_len;
        int last;
        int l;
        kind = $urandom_range(0, 9);
        messages_sent++;
        if (kind == 9)
        begin
            // raw noise: any operation, any byte
            repeat ($urandom_range(3, 10))
                offer(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            return;
        end
        offer(pfe_pkg::OP_START, 8'($urandom_range(0, 255)));
        key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 30)
                                              : $urandom_range(0, 8);
        repeat (key_len)
        begin
            if ($urandom_range(0, 7) == 0)
                offer(pfe_pkg::OP_KEY, 8'($urandom_range(0, 255)));
            else
                offer(pfe_pkg::OP_KEY, letter_byte($urandom_range(0, LETTERS - 1)));
        end
        // leaving out finish key works on a half rebuilt square
        if (kind != 8)
            offer(pfe_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            offer(pfe_pkg::OP_KEY, letter_byte($urandom_range(0, LETTERS - 1)));
        text_len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 16);
        last = $urandom_range(0, LETTERS - 1);
        repeat (text_len)
        begin
            case ($urandom_range(0, 9))
                0: offer(pfe_pkg::OP_PLAIN, 8'($urandom_range(0, 255)));
                1: offer(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                         8'($urandom_range(0, 255)));
                2, 3: offer(pfe_pkg::OP_PLAIN, letter_byte(last));
                default:
                begin
                    l = $urandom_range(0, LETTERS - 1);
                    last = l;
                    offer(pfe_pkg::OP_PLAIN, letter_byte(l));
                end
            endcase
        end
        // sometimes the next start drops a pending letter silently
        if ($urandom_range(0, 7) != 0)
            offer(pfe_pkg::OP_END, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key with lowercase, J folded to I, repeats and non-letters
        offer(pfe_pkg::OP_START, 8'h00);
        offer(pfe_pkg::OP_KEY, "P");
        offer(pfe_pkg::OP_KEY, "l");
        offer(pfe_pkg::OP_KEY, "J");
        offer(pfe_pkg::OP_KEY, "a");
        offer(pfe_pkg::OP_KEY, "p");
        offer(pfe_pkg::OP_KEY, "1");
        offer(pfe_pkg::OP_KEY, 8'hFF);
        offer(pfe_pkg::OP_FINISH, 8'h00);
        // square full: a further key letter is dropped
        offer(pfe_pkg::OP_KEY, "Z");
        offer(OP_SPARE_FIRST, "A");
        offer(OP_SPARE_LAST, 8'hFF);
        // plain pair, J against I as a doubled letter, doubled letter, lone letter
        offer(pfe_pkg::OP_PLAIN, "H");
        offer(pfe_pkg::OP_PLAIN, "I");
        offer(pfe_pkg::OP_PLAIN, "j");
        offer(pfe_pkg::OP_PLAIN, "i");
        offer(pfe_pkg::OP_PLAIN, "E");
        offer(pfe_pkg::OP_PLAIN, "A");
        offer(pfe_pkg::OP_PLAIN, "a");
        offer(pfe_pkg::OP_PLAIN, "!");
        offer(pfe_pkg::OP_END, 8'h7F);
        offer(pfe_pkg::OP_END, 8'h80);
        // no finish key: Z moves to the cell P still claims, both share a cell
        offer(pfe_pkg::OP_START, 8'h00);
        offer(pfe_pkg::OP_KEY, "Z");
        offer(pfe_pkg::OP_PLAIN, "Z");
        offer(pfe_pkg::OP_PLAIN, "P");
        messages_sent = 2;

        while (items_accepted < RANDOM_ITEMS)
            random_message();

        item_valid <= 1'b0;
        while (sb.expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d transactions in %0d messages, %0d cipher pairs checked, %0d mismatches",
                 items_accepted, messages_sent, sb.pairs_checked, sb.mismatches);
        $display("receiver held off %0d cycles once; %0d pairs left unanswered",
                 HOLD_CYCLES, sb.expected_pairs.size());
        if (sb.mismatches == 0 && sb.expected_pairs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/pfe_pkg.sv
sv/pfe_front.sv
sv/pfe_queue.sv
sv/pfe_back.sv
sv/playfair_digraph_encryptor.sv
sv/pfe_checker.sv
bench/tb_playfair_digraph_encryptor.sv
